// ===== hw/rtl/ilir_pkg.sv =====
`default_nettype none

package ilir_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned POS_W   = 7;
  localparam int unsigned COUNT_W = 7;

  typedef enum logic [1:0] {
    KIND_APPEND = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_REMOVE = 2'd2,
    KIND_GET    = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // command broadcast to every cell of the row
  typedef struct packed {
    logic ins;  // write word at index, cells above take their lower neighbor
    logic rem;  // cells at or above index take their upper neighbor
  } cell_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ilir_cell.sv =====
`default_nettype none

module ilir_cell
  import ilir_pkg::*;
#(
  parameter int unsigned IDX   = 0,
  parameter int unsigned CMP_W = 7
) (
  input  wire  logic                     clk_i,
  input  wire  cell_ctl_t                ctl_i,
  input  wire  logic [CMP_W-1:0]         index_i,
  input  wire  logic signed [WORD_W-1:0] word_i,
  input  wire  logic signed [WORD_W-1:0] lower_i,
  input  wire  logic signed [WORD_W-1:0] upper_i,
  output logic signed [WORD_W-1:0]       word_o
);

  localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(IDX);

  logic signed [WORD_W-1:0] word_d, word_q;

  always_comb begin
    word_d = word_q;
    if (ctl_i.ins) begin
      if (MY_IDX == index_i) begin
        word_d = word_i;
      end else if (MY_IDX > index_i) begin
        word_d = lower_i;
      end
    end else if (ctl_i.rem && (MY_IDX >= index_i)) begin
      word_d = upper_i;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;

endmodule

`default_nettype wire

// ===== hw/rtl/indexed_list_insert_remove.sv =====
// the done_o strobe carrying its result comes in the cycle after an accepted start
// throughput: one request per cycle; busy_o stays low, every cell shifts in parallel
// the get path is a single read mux over the row of cells, registered at the output
// reset: asynchronous, active low; clears the entry count and the done strobe,
// entry words are left as they are and are only read once written
// the receiver cannot stall: each result beat is shown for exactly one cycle
`default_nettype none

module indexed_list_insert_remove
  import ilir_pkg::*;
#(
  parameter int unsigned DEPTH = 64
) (
  input  wire  logic                     clk_i,
  input  wire  logic                     rst_ni,
  input  wire  logic                     start_i,
  output logic                           busy_o,
  input  wire  logic [1:0]               kind_i,
  input  wire  logic [POS_W-1:0]         position_i,
  input  wire  logic signed [WORD_W-1:0] word_in_i,
  output logic                           done_o,
  output logic signed [WORD_W-1:0]       word_out_o,
  output logic [1:0]                     status_o,
  output logic [COUNT_W-1:0]             entry_count_o
);

  // count holds 0..DEPTH, compares run at the wider of count and position
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

  logic [CNT_W-1:0] count_d, count_q;
  logic             done_q;
  logic signed [WORD_W-1:0] word_out_q, rd_word;
  status_e          status_d, status_q;
  logic [COUNT_W-1:0] entry_count_q;

  logic             accept;
  kind_e            kind;
  logic [CMP_W-1:0] pos_x, cnt_x, index;
  logic             full;
  cell_ctl_t        ctl;

  // cell words of the row, each read by its neighbors and the get mux
  logic signed [WORD_W-1:0] cell_word [DEPTH];

  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;
  assign kind   = kind_e'(kind_i);
  assign pos_x  = CMP_W'(position_i);
  assign cnt_x  = CMP_W'(count_q);
  assign full   = (count_q >= DEPTH_C);

  // request decode: status, count update and the command for the row
  always_comb begin
    ctl      = '0;
    index    = pos_x;
    count_d  = count_q;
    status_d = ST_OK;
    rd_word  = '0;
    unique case (kind)
      KIND_APPEND: begin
        // append is an insert at the current count
        index = cnt_x;
        if (full) begin
          status_d = ST_FULL;
        end else begin
          ctl.ins = accept;
          count_d = count_q + CNT_W'(1);
        end
      end
      KIND_INSERT: begin
        // an index past the end wins over a full store
        if (pos_x > cnt_x) begin
          status_d = ST_RANGE;
        end else if (full) begin
          status_d = ST_FULL;
        end else begin
          ctl.ins = accept;
          count_d = count_q + CNT_W'(1);
        end
      end
      KIND_REMOVE: begin
        if (pos_x >= cnt_x) begin
          status_d = ST_RANGE;
        end else begin
          // the top cell takes zero, the freed slot takes the word above it
          ctl.rem = accept;
          count_d = count_q - CNT_W'(1);
        end
      end
      KIND_GET: begin
        if (pos_x >= cnt_x) begin
          status_d = ST_RANGE;
        end else begin
          rd_word = cell_word[pos_x[AW-1:0]];
        end
      end
      default: begin
        status_d = ST_RANGE;
      end
    endcase
  end

  // row of cells, each shifting with its neighbors in the same cycle
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [WORD_W-1:0] lower, upper;
    if (g == 0) begin : g_bot
      assign lower = '0;
    end else begin : g_mid_lo
      assign lower = cell_word[g-1];
    end
    if (g == DEPTH - 1) begin : g_top
      assign upper = '0;
    end else begin : g_mid_hi
      assign upper = cell_word[g+1];
    end

    ilir_cell #(
      .IDX   (g),
      .CMP_W (CMP_W)
    ) u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .index_i (index),
      .word_i  (word_in_i),
      .lower_i (lower),
      .upper_i (upper),
      .word_o  (cell_word[g])
    );
  end

  // count and done strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= accept;
      if (accept) begin
        count_q <= count_d;
      end
    end
  end

  // result beat payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      word_out_q    <= rd_word;
      status_q      <= status_d;
      entry_count_q <= COUNT_W'(count_d);
    end
  end

  assign done_o        = done_q;
  assign word_out_o    = word_out_q;
  assign status_o      = status_q;
  assign entry_count_o = entry_count_q;

  // every accepted request gives exactly one beat on the next cycle
  a_one_beat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> done_o)
    else $error("accepted request without result beat");

  a_no_extra_beat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> !done_o)
    else $error("result beat without request");

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DEPTH_C)
    else $error("entry count above depth");

  a_count_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (count_q == $past(count_q)) || (count_q == $past(count_q) + CNT_W'(1))
            || (count_q == $past(count_q) - CNT_W'(1)))
    else $error("entry count moved by more than one");

  a_err_zero_word : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != ST_OK)) |-> (word_out_o == '0))
    else $error("error beat carries a nonzero word");

endmodule

`default_nettype wire
